FILE: sv/xcfp_pkg.sv
// shared types, constants and codes for the xor-checked frame parser
// used by every module of the block except xcfp_ram; depends on nothing
package xcfp_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int MAX_WORDS   = 8;
  localparam int QDEPTH      = 2;
  localparam int CFG_IW      = 2;

  localparam logic [7:0] HEAD1_BYTE = 8'hAA;
  localparam logic [7:0] HEAD2_BYTE = 8'h55;
  localparam logic [7:0] TAIL_BYTE  = 8'hEE;

  localparam logic [7:0] MAX_ID_RST   = 8'd16;
  localparam logic [7:0] FLOAT_ID_RST = 8'd1;
  localparam logic [7:0] COUNT_ID_RST = 8'd5;

  localparam logic [CFG_IW-1:0] REG_MAX_ID   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FLOAT_ID = 2'd1;
  localparam logic [CFG_IW-1:0] REG_COUNT_ID = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ID    = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_CHECK = 3'd3;
  localparam logic [2:0] ST_BAD_TAIL  = 3'd4;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_DATA,
    B_SEND
  } bstate_t;

  // one unit of work handed from the parser to the result side
  typedef struct packed {
    logic        words;
    logic [2:0]  status;
    logic [7:0]  frame_id;
    logic [5:0]  payload_len;
    logic [3:0]  nwords;
    logic [15:0] event_count;
  } job_t;

endpackage

FILE: sv/xor_checked_frame_parser.sv
// top level of the xor-checked frame parser: parser, job queue, result side, payload ram
// depends on xcfp_pkg, xcfp_ram, xcfp_queue, xcfp_front and xcfp_back
//
// Parses frames AA 55 id len payload[len] xor EE from a byte stream. The parser
// takes one byte per cycle while in_tready is high; each frame it finishes or
// rejects becomes one job in a two-entry queue, so bytes keep flowing while
// results wait on out_tready. A status result goes from the job register to the
// output register; float words go one at a time through the registered read of the
// payload ram. While those words are still being read, a new frame's payload
// bytes are held off at in_tready, since the ram has a single buffer; header,
// id, length, check and tail bytes still pass. in_tready also drops while the
// queue is full. cfg_ready is always high; write registers only while idle.
module xor_checked_frame_parser #(
  parameter int MAX_LEN = xcfp_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  input  logic                        in_tlast,   // packet_end
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] frame_id, [13:8] payload_len, [16:14] word_index, [48:17] data_word,
  // [64:49] event_count, [71:65] zero
  output logic [71:0]                 out_tdata,
  output logic [3:0]                  out_tuser,  // [2:0] status, [3] word_valid
  output logic                        out_tlast,  // last
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [xcfp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [7:0]                  cfg_data
);

  localparam int WORDS = (MAX_LEN / 4 < xcfp_pkg::MAX_WORDS) ? MAX_LEN / 4
                                                             : xcfp_pkg::MAX_WORDS;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic           q_full, q_empty, push, pop, words_done;
  xcfp_pkg::job_t push_job, head_job;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata, ram_rdata;

  logic [2:0]  status;
  logic [7:0]  frame_id;
  logic [5:0]  payload_len;
  logic        word_valid;
  logic [2:0]  word_index;
  logic [31:0] data_word;
  logic [15:0] event_count;

  assign cfg_ready = 1'b1;

  xcfp_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .rx_byte    (in_tdata),
    .packet_end (in_tlast),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job),
    .words_done (words_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  xcfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  xcfp_ram #(.W(32), .D(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  xcfp_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head_job    (head_job),
    .pop         (pop),
    .words_done  (words_done),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .status      (status),
    .frame_id    (frame_id),
    .payload_len (payload_len),
    .word_valid  (word_valid),
    .word_index  (word_index),
    .data_word   (data_word),
    .event_count (event_count),
    .last        (out_tlast)
  );

  assign out_tdata = {7'd0, event_count, data_word, word_index, payload_len, frame_id};
  assign out_tuser = {word_valid, status};

endmodule

FILE: sv/xcfp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module xcfp_ram #(
  parameter int W = 32,
  parameter int D = 8,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/xcfp_queue.sv
// short job queue between the parser and the result side
// depends on xcfp_pkg for the job type and depth
module xcfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xcfp_pkg::job_t   push_job,
  input  logic             pop,
  output xcfp_pkg::job_t   head_job,
  output logic             empty,
  output logic             full
);

  localparam int PW = (xcfp_pkg::QDEPTH > 1) ? $clog2(xcfp_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(xcfp_pkg::QDEPTH + 1);

  xcfp_pkg::job_t slot_r [xcfp_pkg::QDEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(xcfp_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(xcfp_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  assign head_job = slot_r[rptr_r];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(xcfp_pkg::QDEPTH));

endmodule

FILE: sv/xcfp_front.sv
// byte parser: config registers, frame state machine, word packing and job issue
// depends on xcfp_pkg; writes payload words into the shared ram
module xcfp_front #(
  parameter int MAX_LEN = xcfp_pkg::MAX_LEN_DEF,
  localparam int WORDS = (MAX_LEN / 4 < xcfp_pkg::MAX_WORDS) ? MAX_LEN / 4
                                                             : xcfp_pkg::MAX_WORDS,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  input  logic                        packet_end,
  input  logic                        cfg_we,
  input  logic [xcfp_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [7:0]                  cfg_val,
  input  logic                        q_full,
  output logic                        push,
  output xcfp_pkg::job_t              push_job,
  input  logic                        words_done,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [31:0]                 ram_wdata
);

  xcfp_pkg::phase_t phase_r, phase_nxt;
  logic             skip_r, skip_nxt;
  logic             wbusy_r, wbusy_nxt;
  logic [7:0]       max_id_r, float_id_r, count_id_r;
  logic [7:0]       id_r, id_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [23:0]      sh_r, sh_nxt;
  logic [15:0]      evt_r, evt_nxt;

  logic          fire;
  logic          act;
  logic [LW:0]   pos_inc;
  logic [3:0]    nwords;
  logic          id_bad;
  logic          len_bad;
  logic          float_hit;
  logic          count_hit;

  // payload writes wait while the previous frame's words are still being read out
  assign in_ready = !q_full && !(phase_r == xcfp_pkg::PH_DATA && wbusy_r && !skip_r);
  assign fire     = in_valid && in_ready;
  assign act      = fire && !skip_r;

  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  assign id_bad    = (rx_byte == 8'd0) || (rx_byte > max_id_r);
  assign len_bad   = rx_byte > 8'(MAX_LEN);
  assign float_hit = (len_r != '0) && (id_r == float_id_r);
  assign count_hit = (len_r != '0) && !float_hit && (id_r == count_id_r);

  always_comb begin
    if ({1'b0, len_r[LW-1:2]} >= (LW-1)'(WORDS)) begin
      nwords = 4'(WORDS);
    end else begin
      nwords = 4'(len_r[LW-1:2]);
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (act) begin
      case (phase_r)
        xcfp_pkg::PH_HEAD1: begin
          if (rx_byte == xcfp_pkg::HEAD1_BYTE) phase_nxt = xcfp_pkg::PH_HEAD2;
        end
        xcfp_pkg::PH_HEAD2: begin
          phase_nxt = (rx_byte == xcfp_pkg::HEAD2_BYTE) ? xcfp_pkg::PH_ID
                                                        : xcfp_pkg::PH_HEAD1;
        end
        xcfp_pkg::PH_ID: begin
          phase_nxt = id_bad ? xcfp_pkg::PH_HEAD1 : xcfp_pkg::PH_LEN;
        end
        xcfp_pkg::PH_LEN: begin
          if (len_bad) begin
            phase_nxt = xcfp_pkg::PH_HEAD1;
          end else if (rx_byte == 8'd0) begin
            phase_nxt = xcfp_pkg::PH_CHECK;
          end else begin
            phase_nxt = xcfp_pkg::PH_DATA;
          end
        end
        xcfp_pkg::PH_DATA: begin
          if (pos_inc >= {1'b0, len_r}) phase_nxt = xcfp_pkg::PH_CHECK;
        end
        xcfp_pkg::PH_CHECK: begin
          phase_nxt = (rx_byte == xor_r) ? xcfp_pkg::PH_TAIL : xcfp_pkg::PH_HEAD1;
        end
        xcfp_pkg::PH_TAIL: phase_nxt = xcfp_pkg::PH_HEAD1;
        default:           phase_nxt = xcfp_pkg::PH_HEAD1;
      endcase
    end
  end

  // datapath, ram writes and job issue
  always_comb begin
    skip_nxt  = skip_r;
    wbusy_nxt = wbusy_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    sh_nxt    = sh_r;
    evt_nxt   = evt_r;
    push      = 1'b0;
    push_job  = '{words: 1'b0, status: xcfp_pkg::ST_OK, frame_id: id_r,
                  payload_len: 6'(len_r), nwords: 4'd0, event_count: evt_r};
    ram_we    = 1'b0;
    ram_waddr = pos_r[AW+1:2];
    ram_wdata = {rx_byte, sh_r};
    if (words_done) wbusy_nxt = 1'b0;
    if (fire && skip_r) begin
      if (packet_end) skip_nxt = 1'b0;
    end else if (act) begin
      case (phase_r)
        xcfp_pkg::PH_ID: begin
          if (id_bad) begin
            push                 = 1'b1;
            push_job.status      = xcfp_pkg::ST_BAD_ID;
            push_job.frame_id    = rx_byte;
            push_job.payload_len = 6'd0;
          end else begin
            id_nxt = rx_byte;
          end
        end
        xcfp_pkg::PH_LEN: begin
          if (len_bad) begin
            push                 = 1'b1;
            push_job.status      = xcfp_pkg::ST_BAD_LEN;
            push_job.payload_len = 6'd0;
          end else begin
            len_nxt = rx_byte[LW-1:0];
            pos_nxt = '0;
            xor_nxt = 8'd0;
          end
        end
        xcfp_pkg::PH_DATA: begin
          xor_nxt = xor_r ^ rx_byte;
          sh_nxt  = {rx_byte, sh_r[23:8]};
          pos_nxt = pos_inc[LW-1:0];
          if (pos_inc >= {1'b0, len_r}) pos_nxt = '0;
          // a full little-endian word lands on every fourth byte
          if (pos_r[1:0] == 2'b11 && {1'b0, pos_r[LW-1:2]} < (LW-1)'(WORDS)) begin
            ram_we = 1'b1;
          end
        end
        xcfp_pkg::PH_CHECK: begin
          if (rx_byte != xor_r) begin
            push            = 1'b1;
            push_job.status = xcfp_pkg::ST_BAD_CHECK;
          end
        end
        xcfp_pkg::PH_TAIL: begin
          if (!packet_end) skip_nxt = 1'b1;
          push = 1'b1;
          if (rx_byte != xcfp_pkg::TAIL_BYTE) begin
            push_job.status = xcfp_pkg::ST_BAD_TAIL;
          end else if (float_hit && nwords != 4'd0) begin
            push_job.words  = 1'b1;
            push_job.nwords = nwords;
            wbusy_nxt       = 1'b1;
          end else if (count_hit) begin
            evt_nxt              = evt_r + 16'd1;
            push_job.event_count = evt_r + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= xcfp_pkg::PH_HEAD1;
      skip_r     <= 1'b0;
      wbusy_r    <= 1'b0;
      id_r       <= 8'd0;
      len_r      <= '0;
      pos_r      <= '0;
      xor_r      <= 8'd0;
      evt_r      <= 16'd0;
      max_id_r   <= xcfp_pkg::MAX_ID_RST;
      float_id_r <= xcfp_pkg::FLOAT_ID_RST;
      count_id_r <= xcfp_pkg::COUNT_ID_RST;
    end else begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      wbusy_r <= wbusy_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
      evt_r   <= evt_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          xcfp_pkg::REG_MAX_ID:   max_id_r   <= cfg_val;
          xcfp_pkg::REG_FLOAT_ID: float_id_r <= cfg_val;
          xcfp_pkg::REG_COUNT_ID: count_id_r <= cfg_val;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

endmodule

FILE: sv/xcfp_back.sv
// result side: takes jobs from the queue, reads payload words and drives the output register
// depends on xcfp_pkg; reads the shared payload ram
module xcfp_back #(
  parameter int MAX_LEN = xcfp_pkg::MAX_LEN_DEF,
  localparam int WORDS = (MAX_LEN / 4 < xcfp_pkg::MAX_WORDS) ? MAX_LEN / 4
                                                             : xcfp_pkg::MAX_WORDS,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  xcfp_pkg::job_t head_job,
  output logic           pop,
  output logic           words_done,
  output logic           ram_re,
  output logic [AW-1:0]  ram_raddr,
  input  logic [31:0]    ram_rdata,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     status,
  output logic [7:0]     frame_id,
  output logic [5:0]     payload_len,
  output logic           word_valid,
  output logic [2:0]     word_index,
  output logic [31:0]    data_word,
  output logic [15:0]    event_count,
  output logic           last
);

  xcfp_pkg::bstate_t state_r, state_nxt;
  xcfp_pkg::job_t    job_r;
  logic [2:0]        widx_r, widx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [2:0]        st_r;
  logic [7:0]        fid_r;
  logic [5:0]        plen_r;
  logic              wv_r;
  logic [2:0]        wi_r;
  logic [31:0]       dw_r;
  logic [15:0]       ec_r;
  logic              last_r;

  logic slot_free;
  logic final_word;
  logic load_word;
  logic load_stat;

  assign slot_free  = !ovalid_r || out_ready;
  assign final_word = ({1'b0, widx_r} + 4'd1) == job_r.nwords;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xcfp_pkg::B_IDLE: begin
        if (!q_empty) state_nxt = head_job.words ? xcfp_pkg::B_RD : xcfp_pkg::B_SEND;
      end
      xcfp_pkg::B_RD:   state_nxt = xcfp_pkg::B_DATA;
      xcfp_pkg::B_DATA: begin
        if (slot_free) state_nxt = final_word ? xcfp_pkg::B_IDLE : xcfp_pkg::B_RD;
      end
      xcfp_pkg::B_SEND: begin
        if (slot_free) state_nxt = xcfp_pkg::B_IDLE;
      end
      default: state_nxt = xcfp_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    ram_re     = 1'b0;
    load_word  = 1'b0;
    load_stat  = 1'b0;
    widx_nxt   = widx_r;
    case (state_r)
      xcfp_pkg::B_IDLE: begin
        pop      = !q_empty;
        widx_nxt = 3'd0;
      end
      xcfp_pkg::B_RD:   ram_re = 1'b1;
      xcfp_pkg::B_DATA: begin
        load_word = slot_free;
        if (slot_free) widx_nxt = widx_r + 3'd1;
      end
      xcfp_pkg::B_SEND: load_stat = slot_free;
      default: begin
      end
    endcase
  end

  assign words_done = load_word && final_word;
  assign ram_raddr  = widx_r[AW-1:0];

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load_word || load_stat) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= xcfp_pkg::B_IDLE;
      ovalid_r <= 1'b0;
      widx_r   <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      widx_r   <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head_job;
    if (load_word || load_stat) begin
      st_r   <= job_r.status;
      fid_r  <= job_r.frame_id;
      plen_r <= job_r.payload_len;
      ec_r   <= job_r.event_count;
      wv_r   <= load_word;
      wi_r   <= load_word ? widx_r : 3'd0;
      dw_r   <= load_word ? ram_rdata : 32'd0;
      last_r <= load_stat || final_word;
    end
  end

  assign out_valid   = ovalid_r;
  assign status      = st_r;
  assign frame_id    = fid_r;
  assign payload_len = plen_r;
  assign word_valid  = wv_r;
  assign word_index  = wi_r;
  assign data_word   = dw_r;
  assign event_count = ec_r;
  assign last        = last_r;

endmodule

FILE: dv/xor_checked_frame_parser_tb.sv
// self-checking testbench for xor_checked_frame_parser: byte stream in, results out
// depends on xcfp_pkg and the xor_checked_frame_parser rtl; reads no files
module xor_checked_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xcfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 56;
  localparam int NUM_DIR = 42;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_id;
    logic [5:0]  payload_len;
    logic        word_valid;
    logic [2:0]  word_index;
    logic [31:0] data_word;
    logic [15:0] event_count;
    logic        last;
  } frame_res_t;

  // directed byte; fixed_ok marks rows whose single status result is typed in
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       pkt_end;
    logic       fixed_ok;
    logic [2:0] status;
    logic [7:0] frame_id;
    logic [5:0] payload_len;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [71:0]         out_tdata;
  logic [3:0]          out_tuser;
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [7:0]          cfg_data;

  xor_checked_frame_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow registers and parser state of the predictor
  logic [7:0]  sh_max_id, sh_float_id, sh_count_id;
  phase_t      p_phase;
  logic        p_skip;
  logic [7:0]  p_id;
  logic [5:0]  p_len;
  logic [5:0]  p_pos;
  logic [7:0]  p_xor;
  logic [7:0]  p_store [MAX_LEN_DEF];
  logic [15:0] p_events;

  frame_res_t  step_res [$];
  frame_res_t  pending_res [$];
  int          errs;
  int          parsed_items;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        pressure_go;
  logic        pressure_done;

  dir_row_t dir_tab [NUM_DIR] = '{
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},  // second header byte wrong
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h00, 1'b0, 1'b1, ST_BAD_ID,    8'h00, 6'd0},  // id zero
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'hFF, 1'b0, 1'b1, ST_BAD_ID,    8'hFF, 6'd0},
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h05, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'hFF, 1'b0, 1'b1, ST_BAD_LEN,   8'h05, 6'd0},
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h05, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},  // zero length, straight to check
    '{8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'hEE, 1'b1, 1'b1, ST_OK,        8'h05, 6'd0},  // counter id but empty: no bump
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h02, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h11, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h00, 1'b0, 1'b1, ST_BAD_CHECK, 8'h02, 6'd1},
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h03, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h5A, 1'b1, 1'b1, ST_BAD_TAIL,  8'h03, 6'd0},
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h04, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h02, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h03, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h04, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'h04, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},
    '{8'hEE, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},  // float frame, tail mid-packet
    '{8'hAA, 1'b0, 1'b0, ST_OK,        8'h00, 6'd0},  // skipped
    '{8'h55, 1'b1, 1'b0, ST_OK,        8'h00, 6'd0}   // skipped, ends the packet
  };

  // max_id, float_id, count_id per random phase
  logic [7:0] phase_cfg [NUM_PHASES][3] = '{
    '{8'd255, 8'd255, 8'd1},
    '{8'd0,   8'd3,   8'd3},
    '{8'd8,   8'd7,   8'd7},
    '{8'd200, 8'd2,   8'd9},
    '{8'd1,   8'd1,   8'd1},
    '{8'd32,  8'd6,   8'd4}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic frame_res_t status_res(input logic [2:0] st, input logic [7:0] id,
                                            input logic [5:0] len);
    frame_res_t r;
    r = '0;
    r.status = st;
    r.frame_id = id;
    r.payload_len = len;
    r.event_count = p_events;
    r.last = 1'b1;
    return r;
  endfunction

  // advances the predicted parser by one byte, leaving its results in step_res
  function automatic void parse_byte(input logic [7:0] b, input logic pe);
    frame_res_t r;
    int nw;
    step_res.delete();
    if (p_skip) begin
      if (pe) p_skip = 1'b0;
      return;
    end
    case (p_phase)
      PH_HEAD1: if (b == HEAD1_BYTE) p_phase = PH_HEAD2;
      PH_HEAD2: p_phase = (b == HEAD2_BYTE) ? PH_ID : PH_HEAD1;
      PH_ID: begin
        if (b == 8'd0 || b > sh_max_id) begin
          p_phase = PH_HEAD1;
          step_res.push_back(status_res(ST_BAD_ID, b, 6'd0));
        end else begin
          p_id = b;
          p_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b > MAX_LEN_DEF) begin
          p_phase = PH_HEAD1;
          step_res.push_back(status_res(ST_BAD_LEN, p_id, 6'd0));
        end else begin
          p_len = b[5:0];
          p_pos = '0;
          p_xor = '0;
          p_phase = (b == 8'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        p_store[p_pos[4:0]] = b;
        p_xor ^= b;
        p_pos++;
        if (p_pos >= p_len) begin
          p_pos = '0;
          p_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b == p_xor) begin
          p_phase = PH_TAIL;
        end else begin
          p_phase = PH_HEAD1;
          step_res.push_back(status_res(ST_BAD_CHECK, p_id, p_len));
        end
      end
      PH_TAIL: begin
        p_phase = PH_HEAD1;
        if (!pe) p_skip = 1'b1;
        if (b != TAIL_BYTE) begin
          step_res.push_back(status_res(ST_BAD_TAIL, p_id, p_len));
        end else if (p_len != 0 && p_id == sh_float_id) begin
          nw = p_len / 4;
          if (nw > MAX_WORDS) nw = MAX_WORDS;
          for (int w = 0; w < nw; w++) begin
            r = status_res(ST_OK, p_id, p_len);
            r.word_valid = 1'b1;
            r.word_index = w[2:0];
            r.data_word = {p_store[4*w+3], p_store[4*w+2], p_store[4*w+1], p_store[4*w]};
            r.last = (w + 1 == nw);
            step_res.push_back(r);
          end
        end else if (p_len != 0 && p_id == sh_count_id) begin
          p_events++;
        end
        // a good frame that emitted no word still reports once
        if (step_res.size() == 0) step_res.push_back(status_res(ST_OK, p_id, p_len));
      end
      default: p_phase = PH_HEAD1;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] b, input logic pe, input logic fixed_ok,
                           input frame_res_t fixed);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= pe;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parsed_items++;
    parse_byte(b, pe);
    if (fixed_ok) pending_res.push_back(fixed);
    else foreach (step_res[k]) pending_res.push_back(step_res[k]);
    @(negedge clk);
  endtask

  // one random frame: mostly well formed, some corrupted, bad length or plain noise
  task automatic send_frame();
    logic [7:0] fr [$];
    logic [7:0] id, len, chk, b;
    int kind, pick, r, tail_pe, extra;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(5, 1))
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
      return;
    end
    pick = $urandom_range(3);
    case (pick)
      0:       id = sh_float_id;
      1:       id = sh_count_id;
      2:       id = 8'($urandom_range((sh_max_id == 0) ? 1 : sh_max_id, 1));
      default: id = 8'($urandom_range(255));
    endcase
    r = $urandom_range(99);
    if (kind >= 70) len = 8'($urandom_range(255, MAX_LEN_DEF + 1));
    else if (r < 10) len = 8'(MAX_LEN_DEF);
    else if (r < 20) len = 8'($urandom_range(MAX_LEN_DEF - 1, 13));
    else len = 8'($urandom_range(12, 0));
    fr = '{HEAD1_BYTE, HEAD2_BYTE, id, len};
    if (kind < 70) begin
      chk = '0;
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(255));
        fr.push_back(b);
        chk ^= b;
      end
      fr.push_back(chk);
      fr.push_back(TAIL_BYTE);
      if ($urandom_range(99) < 15) fr[$urandom_range(fr.size() - 1)] = 8'($urandom_range(255));
    end
    tail_pe = $urandom_range(1);
    foreach (fr[i]) begin
      send_byte(fr[i], (i == fr.size() - 1) ? tail_pe[0] : ($urandom_range(19) == 0),
                1'b0, '0);
    end
    if (!tail_pe) begin
      extra = $urandom_range(3, 1);
      for (int i = 0; i < extra; i++)
        send_byte(8'($urandom_range(255)), (i == extra - 1), 1'b0, '0);
    end
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_ID:   sh_max_id = val;
      REG_FLOAT_ID: sh_float_id = val;
      REG_COUNT_ID: sh_count_id = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off so the input side backs up
  initial begin
    out_tready = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go && !pressure_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : result_mon
    frame_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result item: tdata 0x%0h tuser 0x%0h", out_tdata, out_tuser);
        errs++;
      end else begin
        e = pending_res.pop_front();
        check_field("status", 32'(e.status), 32'(out_tuser[2:0]));
        check_field("frame_id", 32'(e.frame_id), 32'(out_tdata[7:0]));
        check_field("payload_len", 32'(e.payload_len), 32'(out_tdata[13:8]));
        check_field("word_valid", 32'(e.word_valid), 32'(out_tuser[3]));
        check_field("word_index", 32'(e.word_index), 32'(out_tdata[16:14]));
        check_field("data_word", e.data_word, out_tdata[48:17]);
        check_field("event_count", 32'(e.event_count), 32'(out_tdata[64:49]));
        check_field("last", 32'(e.last), 32'(out_tlast));
      end
    end
  end

  initial begin : stimulus
    frame_res_t fixed;
    errs = 0;
    parsed_items = 0;
    pressure_go = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 73;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_max_id = MAX_ID_RST;
    sh_float_id = FLOAT_ID_RST;
    sh_count_id = COUNT_ID_RST;
    p_phase = PH_HEAD1;
    p_skip = 1'b0;
    p_id = '0;
    p_len = '0;
    p_pos = '0;
    p_xor = '0;
    p_events = '0;
    foreach (p_store[i]) p_store[i] = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed bytes at the reset register values
    foreach (dir_tab[i]) begin
      fixed = '0;
      fixed.status = dir_tab[i].status;
      fixed.frame_id = dir_tab[i].frame_id;
      fixed.payload_len = dir_tab[i].payload_len;
      fixed.last = 1'b1;
      send_byte(dir_tab[i].rx_byte, dir_tab[i].pkt_end, dir_tab[i].fixed_ok, fixed);
    end
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0:       begin tx_idle_pct = 9;  rx_idle_pct = 73; end
        1:       begin tx_idle_pct = 73; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      write_reg(REG_MAX_ID, phase_cfg[ph][0]);
      write_reg(REG_FLOAT_ID, phase_cfg[ph][1]);
      write_reg(REG_COUNT_ID, phase_cfg[ph][2]);
      cfg_valid <= 1'b0;
      @(negedge clk);
      if (ph == 4) pressure_go = 1'b1;
      parsed_items = 0;
      while (parsed_items < PHASE_ITEMS) send_frame();
      wait_idle();
    end

    if (errs == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
